/* hw/rtl/dhmc_pkg.sv */
// ----------------------------------------------------------------------------
// dhmc_pkg
// Shared types and constants for the depth hand mask classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package dhmc_pkg;

    localparam int COORD_W = 13;
    localparam int DEPTH_W = 16;
    localparam int LABEL_W = 8;
    localparam int DIFF_W  = COORD_W + 1;       // coordinate difference
    localparam int BAND_W  = DEPTH_W + 1;       // signed depth difference
    localparam int SQ_W    = 2 * DIFF_W;        // one squared difference
    localparam int DIST_W  = SQ_W + 1;          // squared distance
    localparam int PD2_W   = 2 * DEPTH_W;       // squared palm depth
    localparam int PROD_W  = DIST_W + PD2_W;    // distance times depth squared
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = DEPTH_W;

    typedef enum logic [1:0] {
        ACT_PIXEL     = 2'd0,
        ACT_SET_LEFT  = 2'd1,
        ACT_SET_RIGHT = 2'd2,
        ACT_SET_SPINE = 2'd3
    } action_t;

    localparam logic [CFG_AW-1:0] REG_MIN_DEPTH = 1'b0;
    localparam logic [CFG_AW-1:0] REG_MAX_DEPTH = 1'b1;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd300;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd2000;

    localparam logic [LABEL_W-1:0] LABEL_LEFT  = 8'd0;
    localparam logic [LABEL_W-1:0] LABEL_RIGHT = 8'd1;
    localparam logic [LABEL_W-1:0] LABEL_BG    = 8'd255;

    // depth band around a palm, exclusive at both ends
    localparam logic signed [BAND_W-1:0] BAND_HI = 17'sd40;
    localparam logic signed [BAND_W-1:0] BAND_LO = -17'sd90;

    // (30 * 0.95 * 1.5 px*m)^2 = 42750^2 px^2*mm^2
    localparam logic [PROD_W-1:0] RADIUS_SQ = 61'd1827562500;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DEPTH_W-1:0]        depth;
    } pixel_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic [DEPTH_W-1:0]        depth;
        logic                      active;
    } palm_t;

    typedef struct packed {
        palm_t left;
        palm_t right;
    } hands_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] min_depth;
        logic [DEPTH_W-1:0] max_depth;
    } window_t;

endpackage

`default_nettype wire

/* hw/rtl/dhmc_state.sv */
// ----------------------------------------------------------------------------
// dhmc_state
// Palm and spine store plus the depth window registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dhmc_state (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dhmc_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire logic [dhmc_pkg::CFG_DW-1:0]     cfg_wr_data,
    input  wire logic                            set_en,
    input  wire dhmc_pkg::action_t               action,
    input  wire dhmc_pkg::pixel_t                item,
    output dhmc_pkg::hands_t                     hands,
    output dhmc_pkg::window_t                    win
);
    import dhmc_pkg::*;

    logic signed [COORD_W-1:0] l_col_reg, l_row_reg, r_col_reg, r_row_reg, spine_reg;
    logic [DEPTH_W-1:0]        l_depth_reg, r_depth_reg;
    logic [DEPTH_W-1:0]        min_reg, max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_col_reg   <= '0;
            l_row_reg   <= '0;
            l_depth_reg <= '0;
            r_col_reg   <= '0;
            r_row_reg   <= '0;
            r_depth_reg <= '0;
            spine_reg   <= '0;
        end else if (set_en) begin
            case (action)
                ACT_SET_LEFT: begin
                    l_col_reg   <= item.x;
                    l_row_reg   <= item.y;
                    l_depth_reg <= item.depth;
                end
                ACT_SET_RIGHT: begin
                    r_col_reg   <= item.x;
                    r_row_reg   <= item.y;
                    r_depth_reg <= item.depth;
                end
                ACT_SET_SPINE: begin
                    spine_reg <= item.y;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_DEPTH_RST;
            max_reg <= MAX_DEPTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN_DEPTH: min_reg <= cfg_wr_data;
                REG_MAX_DEPTH: max_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // a palm counts while its row is not below the spine row
    always_comb begin
        hands.left.col     = l_col_reg;
        hands.left.row     = l_row_reg;
        hands.left.depth   = l_depth_reg;
        hands.left.active  = (l_row_reg <= spine_reg);
        hands.right.col    = r_col_reg;
        hands.right.row    = r_row_reg;
        hands.right.depth  = r_depth_reg;
        hands.right.active = (r_row_reg <= spine_reg);
        win.min_depth      = min_reg;
        win.max_depth      = max_reg;
    end

endmodule

`default_nettype wire

/* hw/rtl/dhmc_pipe.sv */
// ----------------------------------------------------------------------------
// dhmc_pipe
// Five-stage pixel labelling pipeline with per-stage valid and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module dhmc_pipe (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire dhmc_pkg::pixel_t              item,
    input  wire dhmc_pkg::hands_t              hands,
    input  wire dhmc_pkg::window_t             win,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dhmc_pkg::LABEL_W-1:0]       out_label,
    output logic                               out_left_active,
    output logic                               out_right_active
);
    import dhmc_pkg::*;

    // ---- stage control ----
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic free1, free2, free3, free4, free5;

    assign free5    = !v5_reg || out_ready;
    assign free4    = !v4_reg || free5;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (free1) v1_reg <= in_valid;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
            if (free4) v4_reg <= v3_reg;
            if (free5) v5_reg <= v4_reg;
        end
    end

    // ---- entry: window, band and coordinate differences ----
    logic                       in_win, force_bg_next, force_zero_next;
    logic signed [BAND_W-1:0]   diff_l, diff_r;
    logic                       lok_next, rok_next;

    always_comb begin
        in_win          = (item.depth >= win.min_depth) && (item.depth <= win.max_depth);
        force_bg_next   = !in_win;
        force_zero_next = in_win && ((item.depth == '0) ||
                          (!hands.left.active && !hands.right.active));
        diff_l   = $signed({1'b0, item.depth}) - $signed({1'b0, hands.left.depth});
        diff_r   = $signed({1'b0, item.depth}) - $signed({1'b0, hands.right.depth});
        lok_next = hands.left.active  && (diff_l < BAND_HI) && (diff_l > BAND_LO);
        rok_next = hands.right.active && (diff_r < BAND_HI) && (diff_r > BAND_LO);
    end

    logic                       bg1_reg, zero1_reg, lok1_reg, rok1_reg, la1_reg, ra1_reg;
    logic signed [DIFF_W-1:0]   dxl1_reg, dyl1_reg, dxr1_reg, dyr1_reg;
    logic [DEPTH_W-1:0]         pdl1_reg, pdr1_reg;

    always_ff @(posedge aclk) begin
        if (free1) begin
            bg1_reg   <= force_bg_next;
            zero1_reg <= force_zero_next;
            lok1_reg  <= lok_next;
            rok1_reg  <= rok_next;
            la1_reg   <= hands.left.active;
            ra1_reg   <= hands.right.active;
            dxl1_reg  <= $signed({item.x[COORD_W-1], item.x})
                       - $signed({hands.left.col[COORD_W-1], hands.left.col});
            dyl1_reg  <= $signed({item.y[COORD_W-1], item.y})
                       - $signed({hands.left.row[COORD_W-1], hands.left.row});
            dxr1_reg  <= $signed({item.x[COORD_W-1], item.x})
                       - $signed({hands.right.col[COORD_W-1], hands.right.col});
            dyr1_reg  <= $signed({item.y[COORD_W-1], item.y})
                       - $signed({hands.right.row[COORD_W-1], hands.right.row});
            pdl1_reg  <= hands.left.depth;
            pdr1_reg  <= hands.right.depth;
        end
    end

    // ---- stage 2: squares ----
    logic signed [SQ_W-1:0] sxl_next, syl_next, sxr_next, syr_next;
    logic                   bg2_reg, zero2_reg, lok2_reg, rok2_reg, la2_reg, ra2_reg;
    logic [SQ_W-1:0]        sxl2_reg, syl2_reg, sxr2_reg, syr2_reg;
    logic [PD2_W-1:0]       pdl2_reg, pdr2_reg;

    assign sxl_next = dxl1_reg * dxl1_reg;
    assign syl_next = dyl1_reg * dyl1_reg;
    assign sxr_next = dxr1_reg * dxr1_reg;
    assign syr_next = dyr1_reg * dyr1_reg;

    always_ff @(posedge aclk) begin
        if (free2) begin
            bg2_reg   <= bg1_reg;
            zero2_reg <= zero1_reg;
            lok2_reg  <= lok1_reg;
            rok2_reg  <= rok1_reg;
            la2_reg   <= la1_reg;
            ra2_reg   <= ra1_reg;
            sxl2_reg  <= $unsigned(sxl_next);
            syl2_reg  <= $unsigned(syl_next);
            sxr2_reg  <= $unsigned(sxr_next);
            syr2_reg  <= $unsigned(syr_next);
            pdl2_reg  <= pdl1_reg * pdl1_reg;
            pdr2_reg  <= pdr1_reg * pdr1_reg;
        end
    end

    // ---- stage 3: distances and palm choice, left wins a tie ----
    logic [DIST_W-1:0] dl_next, dr_next;
    logic              pick_left;
    logic              bg3_reg, zero3_reg, miss3_reg, la3_reg, ra3_reg;
    logic [LABEL_W-1:0] sel3_reg;
    logic [DIST_W-1:0] best3_reg;
    logic [PD2_W-1:0]  pd2_3_reg;

    always_comb begin
        dl_next   = {1'b0, sxl2_reg} + {1'b0, syl2_reg};
        dr_next   = {1'b0, sxr2_reg} + {1'b0, syr2_reg};
        pick_left = lok2_reg && (!rok2_reg || (dl_next <= dr_next));
    end

    always_ff @(posedge aclk) begin
        if (free3) begin
            bg3_reg   <= bg2_reg;
            zero3_reg <= zero2_reg;
            miss3_reg <= !lok2_reg && !rok2_reg;
            la3_reg   <= la2_reg;
            ra3_reg   <= ra2_reg;
            sel3_reg  <= pick_left ? LABEL_LEFT : LABEL_RIGHT;
            best3_reg <= pick_left ? dl_next : dr_next;
            pd2_3_reg <= pick_left ? pdl2_reg : pdr2_reg;
        end
    end

    // ---- stage 4: radius product ----
    logic               bg4_reg, zero4_reg, miss4_reg, pdz4_reg, la4_reg, ra4_reg;
    logic [LABEL_W-1:0] sel4_reg;
    logic [PROD_W-1:0]  prod4_reg;

    always_ff @(posedge aclk) begin
        if (free4) begin
            bg4_reg   <= bg3_reg;
            zero4_reg <= zero3_reg;
            miss4_reg <= miss3_reg;
            pdz4_reg  <= (pd2_3_reg == '0);
            la4_reg   <= la3_reg;
            ra4_reg   <= ra3_reg;
            sel4_reg  <= sel3_reg;
            prod4_reg <= PROD_W'(best3_reg) * PROD_W'(pd2_3_reg);
        end
    end

    // ---- stage 5: final label, held here until taken ----
    logic [LABEL_W-1:0] label_next;
    logic [LABEL_W-1:0] label5_reg;
    logic               la5_reg, ra5_reg;

    always_comb begin
        if (bg4_reg) begin
            label_next = LABEL_BG;
        end else if (zero4_reg) begin
            label_next = LABEL_LEFT;
        end else if (miss4_reg) begin
            label_next = LABEL_BG;
        end else if (!pdz4_reg && (prod4_reg > RADIUS_SQ)) begin
            label_next = LABEL_BG;
        end else begin
            label_next = sel4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (free5) begin
            label5_reg <= label_next;
            la5_reg    <= la4_reg;
            ra5_reg    <= ra4_reg;
        end
    end

    assign out_valid        = v5_reg;
    assign out_label        = label5_reg;
    assign out_left_active  = la5_reg;
    assign out_right_active = ra5_reg;

endmodule

`default_nettype wire

/* hw/rtl/depth_hand_mask_classifier.sv */
// ----------------------------------------------------------------------------
// depth_hand_mask_classifier
// Labels depth pixels as left hand, right hand or background.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the full pipeline is stalled;
// a pixel's label is produced by the five-stage pipeline (window and band
// test, squares, distance compare, radius product, label).
// Palm and spine set items are absorbed at acceptance and give no output;
// every pixel sees the palm data written by all set items accepted before
// it. Backpressure stalls each stage only when the one after it is full, so
// the input keeps accepting while a finished label waits, until every stage is full.
// Write the depth window only while no pixel is in flight.
`default_nettype none

module depth_hand_mask_classifier (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [dhmc_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [dhmc_pkg::CFG_DW-1:0]   cfg_wr_data,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [47:0]                   s_axis_tdata,  // coord_x, coord_y, depth_mm
    input  wire logic [1:0]                    s_axis_tuser,  // action
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // mask_label
    output logic [1:0]                         m_axis_tuser   // left_active, right_active
);
    import dhmc_pkg::*;

    pixel_t  item;
    action_t action;
    hands_t  hands;
    window_t win;
    logic    is_pixel;
    logic    set_en;

    // unpack the input item
    always_comb begin
        item.x     = $signed(s_axis_tdata[12:0]);
        item.y     = $signed(s_axis_tdata[25:13]);
        item.depth = s_axis_tdata[41:26];
        action     = action_t'(s_axis_tuser);
    end

    assign is_pixel = (action == ACT_PIXEL);
    // store palm or spine data as the set item is accepted
    assign set_en   = s_axis_tvalid && s_axis_tready && !is_pixel;

    dhmc_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .set_en      (set_en),
        .action      (action),
        .item        (item),
        .hands       (hands),
        .win         (win)
    );

    // only pixels enter the pipeline; set items share its ready
    dhmc_pipe u_pipe (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_axis_tvalid && is_pixel),
        .in_ready         (s_axis_tready),
        .item             (item),
        .hands            (hands),
        .win              (win),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_label        (m_axis_tdata),
        .out_left_active  (m_axis_tuser[0]),
        .out_right_active (m_axis_tuser[1])
    );

    // labels are left, right or background only
    a_label_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata == LABEL_LEFT) || (m_axis_tdata == LABEL_RIGHT)
                          || (m_axis_tdata == LABEL_BG))
        else $error("label outside the label set");

    // a right-hand label needs an active right palm
    a_right_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata == LABEL_RIGHT) |-> m_axis_tuser[1])
        else $error("right label with inactive right palm");

    // input stalls only when the output holds a label that is not taken
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a free-flowing output never blocks the input in the next cycle
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |=> s_axis_tready || $past(!s_axis_tready) || !m_axis_tready)
        else $error("input blocked while output drains");

endmodule

`default_nettype wire
